FILE: design/paz_pkg.sv
// package for the pressure autozero offset corrector
// widths, payload types, register codes, the magnitude function and the saturating add; no dependencies
`timescale 1ns / 1ps

package paz_pkg;

    localparam int unsigned SAMPLE_W      = 24;
    localparam int unsigned SUM_W         = 32;
    localparam int unsigned LIMIT_W       = 23;
    localparam int unsigned COUNT_W       = 7;
    localparam int unsigned AVG_COUNT_DEF = 100;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [SAMPLE_W-1:0] t_mag;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic        [LIMIT_W-1:0]  t_limit;
    typedef logic        [COUNT_W-1:0]  t_count;

    localparam t_limit LIMIT_RESET = 23'd12800;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_LOADED_A = 2'd0,
        REG_LOADED_B = 2'd1,
        REG_LOADED_C = 2'd2,
        REG_LIMIT    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_sample loaded_a;
        t_sample loaded_b;
        t_sample loaded_c;
        t_limit  limit;
        logic    loaded_ok;
    } t_cfg;

    typedef struct packed {
        t_sample a;
        t_sample b;
        t_sample c;
    } t_triple;

    // one item as it travels down the pipeline
    typedef struct packed {
        t_triple smp;
        logic    last;
        logic    done;
        logic    store;
    } t_item;

    // load strobes for the divider stages
    typedef struct packed {
        logic x;
        logic q0;
        logic rem;
    } t_div_en;

    typedef struct packed {
        t_triple corrected;
        logic    done;
        logic    store;
        t_triple offset;
    } t_result;

    function automatic t_mag mag24(input t_sample v);
        t_mag m;
        m = v[SAMPLE_W-1] ? t_mag'(-v) : t_mag'(v);
        return m;
    endfunction

    function automatic t_sample sat_add(input t_sample s, input t_sample o);
        logic signed [SAMPLE_W:0] w;
        t_sample r;
        w = {s[SAMPLE_W-1], s} + {o[SAMPLE_W-1], o};
        if (w[SAMPLE_W] != w[SAMPLE_W-1]) begin
            r = w[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            r = w[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: design/paz_if.sv
// handshake channels of the pressure autozero offset corrector
// depends on paz_pkg
`timescale 1ns / 1ps

interface paz_sample_if;
    import paz_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample_a;
    t_sample sample_b;
    t_sample sample_c;

    modport source (output valid, output sample_a, output sample_b, output sample_c,
                    input ready);
    modport sink   (input valid, input sample_a, input sample_b, input sample_c,
                    output ready);
endinterface

interface paz_result_if;
    import paz_pkg::*;
    logic    valid;
    logic    ready;
    t_sample corrected_a;
    t_sample corrected_b;
    t_sample corrected_c;
    logic    calibration_done;
    logic    store_request;
    t_sample new_offset_a;
    t_sample new_offset_b;
    t_sample new_offset_c;

    modport source (output valid, output corrected_a, output corrected_b, output corrected_c,
                    output calibration_done, output store_request, output new_offset_a,
                    output new_offset_b, output new_offset_c, input ready);
    modport sink   (input valid, input corrected_a, input corrected_b, input corrected_c,
                    input calibration_done, input store_request, input new_offset_a,
                    input new_offset_b, input new_offset_c, output ready);
endinterface

interface paz_cfg_if;
    import paz_pkg::*;
    logic                valid;
    logic                ready;
    t_reg_idx            index;
    logic [SAMPLE_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/paz_cfg.sv
// configuration registers and the loaded-offset range check
// depends on paz_pkg and paz_cfg_if
`timescale 1ns / 1ps

module paz_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    paz_cfg_if.sink       i_cfg,
    output paz_pkg::t_cfg o_cfg
);
    import paz_pkg::*;

    t_sample r_loaded_a, r_loaded_b, r_loaded_c;
    t_limit  r_limit;
    logic    r_loaded_ok;
    logic    n_loaded_ok;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded_a <= '0;
            r_loaded_b <= '0;
            r_loaded_c <= '0;
            r_limit    <= LIMIT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_LOADED_A: r_loaded_a <= t_sample'(i_cfg.data);
                REG_LOADED_B: r_loaded_b <= t_sample'(i_cfg.data);
                REG_LOADED_C: r_loaded_c <= t_sample'(i_cfg.data);
                REG_LIMIT:    r_limit    <= i_cfg.data[LIMIT_W-1:0];
                default:      ;
            endcase
        end
    end

    // all three loaded offsets must be inside the limit
    always_comb begin
        n_loaded_ok = (mag24(r_loaded_a) <= {1'b0, r_limit}) &&
                      (mag24(r_loaded_b) <= {1'b0, r_limit}) &&
                      (mag24(r_loaded_c) <= {1'b0, r_limit});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded_ok <= 1'b1;
        end else begin
            r_loaded_ok <= n_loaded_ok;
        end
    end

    assign o_cfg = '{loaded_a: r_loaded_a, loaded_b: r_loaded_b, loaded_c: r_loaded_c,
                     limit: r_limit, loaded_ok: r_loaded_ok};

endmodule

FILE: design/paz_rdiv.sv
// rounded mean of one channel sum: reciprocal multiply with one correction step
// depends on paz_pkg
`timescale 1ns / 1ps

module paz_rdiv #(
    parameter int unsigned AVERAGE_COUNT = paz_pkg::AVG_COUNT_DEF
) (
    input  logic             i_clk,
    input  paz_pkg::t_div_en i_en,
    input  paz_pkg::t_sum    i_sum,
    input  paz_pkg::t_limit  i_limit,
    output paz_pkg::t_sample o_cand,
    output logic             o_within
);
    import paz_pkg::*;

    localparam logic [SUM_W:0]   RECIP = (SUM_W+1)'((65'd1 << SUM_W) / AVERAGE_COUNT);
    localparam logic [SUM_W-1:0] HALF  = SUM_W'(AVERAGE_COUNT / 2);
    localparam logic [SUM_W-1:0] DIVR  = SUM_W'(AVERAGE_COUNT);
    localparam logic [7:0]       DIV8  = 8'(AVERAGE_COUNT);

    logic [SUM_W-1:0] r_x, r_x2, r_q0, r_q1;
    logic             r_neg, r_neg2, r_neg3;
    logic [7:0]       r_rem;
    logic [SUM_W-1:0] n_x, qn, diff, q;
    logic [2*SUM_W:0] prod;

    // magnitude plus half the divisor
    always_comb begin
        n_x = (i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum)) + HALF;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.x) begin
            r_x   <= n_x;
            r_neg <= i_sum[SUM_W-1];
        end
    end

    // quotient estimate, at most one short
    assign prod = (2*SUM_W+1)'(r_x) * (2*SUM_W+1)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en.q0) begin
            r_q0   <= prod[2*SUM_W-1:SUM_W];
            r_x2   <= r_x;
            r_neg2 <= r_neg;
        end
    end

    assign qn   = r_q0 * DIVR;
    assign diff = r_x2 - qn;

    always_ff @(posedge i_clk) begin
        if (i_en.rem) begin
            r_rem  <= diff[7:0];
            r_q1   <= r_q0;
            r_neg3 <= r_neg2;
        end
    end

    always_comb begin
        q        = r_q1 + ((r_rem >= DIV8) ? SUM_W'(1) : SUM_W'(0));
        o_within = q <= SUM_W'(i_limit);
        o_cand   = r_neg3 ? t_sample'(q[SAMPLE_W-1:0]) : t_sample'(-q[SAMPLE_W-1:0]);
    end

endmodule

FILE: design/paz_corr.sv
// offset selection and saturating correction of the three channels
// depends on paz_pkg
`timescale 1ns / 1ps

module paz_corr (
    input  paz_pkg::t_triple i_smp,
    input  paz_pkg::t_triple i_learned,
    input  logic             i_learned_valid,
    input  paz_pkg::t_cfg    i_cfg,
    output paz_pkg::t_triple o_corrected,
    output paz_pkg::t_triple o_offset
);
    import paz_pkg::*;

    t_triple use_off;

    always_comb begin
        if (i_learned_valid) begin
            use_off = i_learned;
        end else if (i_cfg.loaded_ok) begin
            use_off = '{a: i_cfg.loaded_a, b: i_cfg.loaded_b, c: i_cfg.loaded_c};
        end else begin
            use_off = '0;
        end
        o_offset      = use_off;
        o_corrected.a = sat_add(i_smp.a, use_off.a);
        o_corrected.b = sat_add(i_smp.b, use_off.b);
        o_corrected.c = sat_add(i_smp.c, use_off.c);
    end

endmodule

FILE: design/pressure_autozero_offset.sv
// top level of the three-channel pressure autozero offset corrector
// depends on paz_pkg, paz_if, paz_cfg, paz_rdiv and paz_corr
`timescale 1ns / 1ps

// Three-channel pressure offset corrector with automatic zero calibration,
// pressures in 1/256 Pa two's complement. One sample item is taken per clock
// while the result output is not stalled, and every item yields one result
// item, in order. The rounded-mean divider, a reciprocal multiply followed by
// a multiply-back correction, is pipelined so the throughput stays one item
// per cycle with no stalls of its own. The first AVERAGE_COUNT items are
// summed per channel; the item that completes the sum gets candidate offsets
// of minus the rounded mean (ties away from zero), and they are adopted with
// store_request only when every magnitude is within offset_limit. Until then
// the loaded offsets are used if all are within the limit, zero otherwise.
// Output is sample plus offset, saturated to 24 bits.
// Configuration writes must be made while no item is in flight.
module pressure_autozero_offset #(
    parameter int unsigned AVERAGE_COUNT = paz_pkg::AVG_COUNT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    paz_sample_if.sink   i_sample,
    paz_result_if.source o_result,
    paz_cfg_if.sink      i_cfg
);
    import paz_pkg::*;

    localparam t_count COUNT_N = COUNT_W'(AVERAGE_COUNT);

    // pipeline control: stage k holds one item when r_v[k] is set
    logic [6:1] r_v;
    logic [6:1] en;
    logic       en_out;
    logic       r_out_valid;
    t_item      r_item [1:6];
    t_result    r_out;

    // accumulation state
    t_sum   r_sum_a, r_sum_b, r_sum_c;
    t_count r_count;
    logic   r_acc;
    t_count count_inc;
    logic   hit_last;

    // learned offsets
    logic    r_learned_valid;
    t_triple r_learned;

    t_cfg    cfg;
    t_div_en div_en;
    t_sample cand_a, cand_b, cand_c;
    logic    within_a, within_b, within_c;
    logic    adopt;
    t_triple corrected, use_off;

    paz_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // handshake chain, each stage moves when the next one frees up
    always_comb begin
        en_out = r_v[6] && (!r_out_valid || o_result.ready);
        en[6]  = r_v[5] && (!r_v[6] || en_out);
        en[5]  = r_v[4] && (!r_v[5] || en[6]);
        en[4]  = r_v[3] && (!r_v[4] || en[5]);
        en[3]  = r_v[2] && (!r_v[3] || en[4]);
        en[2]  = r_v[1] && (!r_v[2] || en[3]);
        en[1]  = i_sample.valid && i_sample.ready;
    end

    assign i_sample.ready = !r_v[1] || en[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_v[1]      <= en[1] || (r_v[1] && !en[2]);
            r_v[2]      <= en[2] || (r_v[2] && !en[3]);
            r_v[3]      <= en[3] || (r_v[3] && !en[4]);
            r_v[4]      <= en[4] || (r_v[4] && !en[5]);
            r_v[5]      <= en[5] || (r_v[5] && !en[6]);
            r_v[6]      <= en[6] || (r_v[6] && !en_out);
            r_out_valid <= en_out || (r_out_valid && !o_result.ready);
        end
    end

    // stage 1 -> 2: accumulate while calibrating
    assign count_inc = r_count + t_count'(1);
    assign hit_last  = r_acc && (count_inc == COUNT_N);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_sum_c <= '0;
            r_count <= '0;
            r_acc   <= 1'b1;
        end else if (en[2] && r_acc) begin
            r_sum_a <= r_sum_a + SUM_W'(r_item[1].smp.a);
            r_sum_b <= r_sum_b + SUM_W'(r_item[1].smp.b);
            r_sum_c <= r_sum_c + SUM_W'(r_item[1].smp.c);
            r_count <= count_inc;
            if (hit_last) begin
                r_acc <= 1'b0;
            end
        end
    end

    // stage 1 takes the raw sample, later stages shift the item along
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_item[1].smp   <= '{a: i_sample.sample_a, b: i_sample.sample_b,
                                 c: i_sample.sample_c};
            r_item[1].last  <= 1'b0;
            r_item[1].done  <= 1'b0;
            r_item[1].store <= 1'b0;
        end
        if (en[2]) begin
            r_item[2].smp   <= r_item[1].smp;
            r_item[2].last  <= hit_last;
            r_item[2].done  <= !r_acc || hit_last;
            r_item[2].store <= 1'b0;
        end
        if (en[3]) begin
            r_item[3] <= r_item[2];
        end
        if (en[4]) begin
            r_item[4] <= r_item[3];
        end
        if (en[5]) begin
            r_item[5] <= r_item[4];
        end
        if (en[6]) begin
            r_item[6].smp   <= r_item[5].smp;
            r_item[6].last  <= r_item[5].last;
            r_item[6].done  <= r_item[5].done;
            r_item[6].store <= adopt;
        end
    end

    // the sums stop changing after the last item, so the divider can read
    // them straight from the accumulators when that item sits in stage 2
    assign div_en = '{x: en[3], q0: en[4], rem: en[5]};

    paz_rdiv #(.AVERAGE_COUNT(AVERAGE_COUNT)) u_rdiv_a (
        .i_clk (i_clk), .i_en (div_en), .i_sum (r_sum_a), .i_limit (cfg.limit),
        .o_cand (cand_a), .o_within (within_a)
    );

    paz_rdiv #(.AVERAGE_COUNT(AVERAGE_COUNT)) u_rdiv_b (
        .i_clk (i_clk), .i_en (div_en), .i_sum (r_sum_b), .i_limit (cfg.limit),
        .o_cand (cand_b), .o_within (within_b)
    );

    paz_rdiv #(.AVERAGE_COUNT(AVERAGE_COUNT)) u_rdiv_c (
        .i_clk (i_clk), .i_en (div_en), .i_sum (r_sum_c), .i_limit (cfg.limit),
        .o_cand (cand_c), .o_within (within_c)
    );

    // stage 5 -> 6: adopt the candidates when all are inside the limit
    assign adopt = r_item[5].last && within_a && within_b && within_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learned_valid <= 1'b0;
        end else if (en[6] && adopt) begin
            r_learned_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6] && adopt) begin
            r_learned <= '{a: cand_a, b: cand_b, c: cand_c};
        end
    end

    // stage 6 -> result register: pick the offsets and correct
    paz_corr u_corr (
        .i_smp           (r_item[6].smp),
        .i_learned       (r_learned),
        .i_learned_valid (r_learned_valid),
        .i_cfg           (cfg),
        .o_corrected     (corrected),
        .o_offset        (use_off)
    );

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out.corrected <= corrected;
            r_out.done      <= r_item[6].done;
            r_out.store     <= r_item[6].store;
            r_out.offset    <= use_off;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.corrected_a      = r_out.corrected.a;
    assign o_result.corrected_b      = r_out.corrected.b;
    assign o_result.corrected_c      = r_out.corrected.c;
    assign o_result.calibration_done = r_out.done;
    assign o_result.store_request    = r_out.store;
    assign o_result.new_offset_a     = r_out.offset.a;
    assign o_result.new_offset_b     = r_out.offset.b;
    assign o_result.new_offset_c     = r_out.offset.c;

    // a store request only ever comes with a finished calibration
    a_store_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.store |-> r_out.done)
        else $error("store request without calibration done");

    // the sample count never passes the averaging length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc |-> (r_count < COUNT_N))
        else $error("sample count past averaging length");

    // calibration, once over, does not restart
    a_acc_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_acc |=> !r_acc)
        else $error("accumulation restarted");

    // learned offsets exist only after accumulation has ended
    a_learned_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_learned_valid |-> !r_acc)
        else $error("learned offsets while accumulating");

    // sums freeze once calibration is over
    a_sums_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_acc |=> $stable(r_sum_a) && $stable(r_sum_b) && $stable(r_sum_c))
        else $error("sums changed after calibration");

endmodule
